FILE: design/gpio_pkg.sv
// gpio_pkg: field widths, function and register codes, and the struct types
// shared by the GPIO port modules and channel interfaces. No dependencies.
`default_nettype none

package gpio_pkg;

    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 4;
    localparam int DATA_W  = 32;
    localparam int PINS_W  = 16;

    // transfer function codes
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TICK  = 2'd2;

    // register map
    localparam logic [INDEX_W-1:0] REG_MODE     = 4'd0;
    localparam logic [INDEX_W-1:0] REG_OTYPE    = 4'd1;
    localparam logic [INDEX_W-1:0] REG_SPEED    = 4'd2;
    localparam logic [INDEX_W-1:0] REG_PULL     = 4'd3;
    localparam logic [INDEX_W-1:0] REG_IDR      = 4'd4;
    localparam logic [INDEX_W-1:0] REG_ODR      = 4'd5;
    localparam logic [INDEX_W-1:0] REG_SETRESET = 4'd6;
    localparam logic [INDEX_W-1:0] REG_AFL      = 4'd7;
    localparam logic [INDEX_W-1:0] REG_AFH      = 4'd8;
    localparam logic [INDEX_W-1:0] REG_RISE     = 4'd9;
    localparam logic [INDEX_W-1:0] REG_FALL     = 4'd10;
    localparam logic [INDEX_W-1:0] REG_MASK     = 4'd11;
    localparam logic [INDEX_W-1:0] REG_PENDING  = 4'd12;

    localparam logic [1:0] MODE_OUTPUT = 2'b01;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] reg_index;
        logic [DATA_W-1:0]  write_data;
        logic [PINS_W-1:0]  pin_levels;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [PINS_W-1:0] pin_drive;
        logic [PINS_W-1:0] drive_enable;
        logic [PINS_W-1:0] open_drain;
        logic              irq;
    } t_status;

endpackage

`default_nettype wire

FILE: design/gpio_ifs.sv
// gpio_ifs: valid/ready channel interfaces for the GPIO port's request and
// result streams. Depends on gpio_pkg for field widths.
`default_nettype none

interface gpio_req_if;
    logic                          valid;
    logic                          ready;
    logic [gpio_pkg::FUNC_W-1:0]   func;
    logic [gpio_pkg::INDEX_W-1:0]  reg_index;
    logic [gpio_pkg::DATA_W-1:0]   write_data;
    logic [gpio_pkg::PINS_W-1:0]   pin_levels;

    modport source (output valid, func, reg_index, write_data, pin_levels, input ready);
    modport sink   (input valid, func, reg_index, write_data, pin_levels, output ready);
endinterface

interface gpio_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gpio_pkg::DATA_W-1:0]   read_data;
    logic [gpio_pkg::PINS_W-1:0]   pin_drive;
    logic [gpio_pkg::PINS_W-1:0]   drive_enable;
    logic [gpio_pkg::PINS_W-1:0]   open_drain;
    logic                          irq;

    modport source (output valid, read_data, pin_drive, drive_enable, open_drain, irq,
                    input ready);
    modport sink   (input valid, read_data, pin_drive, drive_enable, open_drain, irq,
                    output ready);
endinterface

`default_nettype wire

FILE: design/gpio_regs.sv
// gpio_regs: GPIO port register file, set/reset logic and edge-triggered
// pending bits. Updates on i_en; o_status reflects the post-update state.
// Depends on gpio_pkg.
`default_nettype none

module gpio_regs #(
    parameter int PIN_COUNT = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire gpio_pkg::t_item i_item,
    output gpio_pkg::t_status    o_status
);

    localparam int AFL_PINS = (PIN_COUNT >= 8) ? 8 : PIN_COUNT;
    localparam int AFH_PINS = (PIN_COUNT > 8) ? (PIN_COUNT - 8) : 0;

    localparam logic [15:0] PIN_MASK   = 16'((64'd1 << PIN_COUNT) - 64'd1);
    localparam logic [31:0] FIELD_MASK = 32'((64'd1 << (2 * PIN_COUNT)) - 64'd1);
    localparam logic [31:0] AFL_MASK   = 32'((64'd1 << (4 * AFL_PINS)) - 64'd1);
    localparam logic [31:0] AFH_MASK   = 32'((64'd1 << (4 * AFH_PINS)) - 64'd1);

    logic [31:0] r_mode, n_mode;
    logic [31:0] r_speed, n_speed;
    logic [31:0] r_pull, n_pull;
    logic [31:0] r_afl, n_afl;
    logic [31:0] r_afh, n_afh;
    logic [15:0] r_otype, n_otype;
    logic [15:0] r_odr, n_odr;
    logic [15:0] r_idr, n_idr;
    logic [15:0] r_rise, n_rise;
    logic [15:0] r_fall, n_fall;
    logic [15:0] r_mask, n_mask;
    logic [15:0] r_pend, n_pend;

    logic [15:0] now_lvl;
    logic [15:0] edges;
    logic [31:0] rd_data;
    logic [15:0] drv_en;

    assign now_lvl = i_item.pin_levels & PIN_MASK;
    assign edges   = ((now_lvl & ~r_idr & r_rise) | (~now_lvl & r_idr & r_fall)) & r_mask;

    always_comb begin
        n_mode  = r_mode;
        n_speed = r_speed;
        n_pull  = r_pull;
        n_afl   = r_afl;
        n_afh   = r_afh;
        n_otype = r_otype;
        n_odr   = r_odr;
        n_idr   = r_idr;
        n_rise  = r_rise;
        n_fall  = r_fall;
        n_mask  = r_mask;
        n_pend  = r_pend;
        case (i_item.func)
            gpio_pkg::FN_WRITE: begin
                case (i_item.reg_index)
                    gpio_pkg::REG_MODE:     n_mode  = i_item.write_data & FIELD_MASK;
                    gpio_pkg::REG_OTYPE:    n_otype = i_item.write_data[15:0] & PIN_MASK;
                    gpio_pkg::REG_SPEED:    n_speed = i_item.write_data & FIELD_MASK;
                    gpio_pkg::REG_PULL:     n_pull  = i_item.write_data & FIELD_MASK;
                    gpio_pkg::REG_ODR:      n_odr   = i_item.write_data[15:0] & PIN_MASK;
                    // set bits win over reset bits
                    gpio_pkg::REG_SETRESET: n_odr = ((r_odr & ~i_item.write_data[31:16])
                                                     | i_item.write_data[15:0]) & PIN_MASK;
                    gpio_pkg::REG_AFL:      n_afl   = i_item.write_data & AFL_MASK;
                    gpio_pkg::REG_AFH:      n_afh   = i_item.write_data & AFH_MASK;
                    gpio_pkg::REG_RISE:     n_rise  = i_item.write_data[15:0] & PIN_MASK;
                    gpio_pkg::REG_FALL:     n_fall  = i_item.write_data[15:0] & PIN_MASK;
                    gpio_pkg::REG_MASK:     n_mask  = i_item.write_data[15:0] & PIN_MASK;
                    // write one to clear
                    gpio_pkg::REG_PENDING:  n_pend  = r_pend & ~i_item.write_data[15:0]
                                                      & PIN_MASK;
                    default: ;
                endcase
            end
            gpio_pkg::FN_TICK: begin
                n_pend = (r_pend | edges) & PIN_MASK;
                n_idr  = now_lvl;
            end
            default: ;
        endcase
    end

    // reads leave state alone, so current contents are the post-update ones
    always_comb begin
        rd_data = '0;
        if (i_item.func == gpio_pkg::FN_READ) begin
            case (i_item.reg_index)
                gpio_pkg::REG_MODE:    rd_data = r_mode;
                gpio_pkg::REG_OTYPE:   rd_data = {16'd0, r_otype};
                gpio_pkg::REG_SPEED:   rd_data = r_speed;
                gpio_pkg::REG_PULL:    rd_data = r_pull;
                gpio_pkg::REG_IDR:     rd_data = {16'd0, r_idr};
                gpio_pkg::REG_ODR:     rd_data = {16'd0, r_odr};
                gpio_pkg::REG_AFL:     rd_data = r_afl;
                gpio_pkg::REG_AFH:     rd_data = r_afh;
                gpio_pkg::REG_RISE:    rd_data = {16'd0, r_rise};
                gpio_pkg::REG_FALL:    rd_data = {16'd0, r_fall};
                gpio_pkg::REG_MASK:    rd_data = {16'd0, r_mask};
                gpio_pkg::REG_PENDING: rd_data = {16'd0, r_pend};
                default:               rd_data = '0;
            endcase
        end
    end

    always_comb begin
        for (int p = 0; p < 16; p++) begin
            drv_en[p] = (n_mode[2*p +: 2] == gpio_pkg::MODE_OUTPUT);
        end
    end

    assign o_status.read_data    = rd_data;
    assign o_status.pin_drive    = n_odr;
    assign o_status.drive_enable = drv_en;
    assign o_status.open_drain   = n_otype;
    assign o_status.irq          = |n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_speed <= '0;
            r_pull  <= '0;
            r_afl   <= '0;
            r_afh   <= '0;
            r_otype <= '0;
            r_odr   <= '0;
            r_idr   <= '0;
            r_rise  <= '0;
            r_fall  <= '0;
            r_mask  <= '0;
            r_pend  <= '0;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_speed <= n_speed;
            r_pull  <= n_pull;
            r_afl   <= n_afl;
            r_afh   <= n_afh;
            r_otype <= n_otype;
            r_odr   <= n_odr;
            r_idr   <= n_idr;
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_mask  <= n_mask;
            r_pend  <= n_pend;
        end
    end

endmodule

`default_nettype wire

FILE: design/gpio_port_with_edge_interrupts.sv
// GPIO port with edge-triggered interrupts: top level with request/result
// channels and the result register. Depends on gpio_pkg, gpio_ifs, gpio_regs.
//
// Sixteen-pin (PIN_COUNT) general-purpose I/O port. Every request transfer is a
// register read, a register write or a pin sample tick, and produces exactly
// one result transfer: read data (zero for writes and ticks) plus the port's
// drive, drive-enable, open-drain and irq state after the request's update,
// held in the result register until taken. Throughput is one request per
// clock while results are taken. The request side keeps accepting while
// a result waits, as long as the result is taken in the same cycle. Register
// map: 0 mode, 1 output type, 2 speed, 3 pull, 4 input data (read-only),
// 5 output data, 6 set/reset (set wins, reads zero), 7/8 alternate function
// low/high, 9 rising trigger, 10 falling trigger, 11 interrupt mask (one
// unmasks), 12 pending (write one to clear). Indexes 13-15 read zero and
// ignore writes. On a tick the pins are latched into input data; an enabled
// edge on an unmasked pin sets its pending bit and irq stays high while any
// pending bit is set. Edges on the first tick are taken against the reset
// value of zero. Bits of pins at or above PIN_COUNT read as zero. All
// registers reset to zero.
`default_nettype none

module gpio_port_with_edge_interrupts #(
    parameter int PIN_COUNT = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    gpio_req_if.sink  i_req,
    gpio_rsp_if.source o_rsp
);

    gpio_pkg::t_item   item;
    gpio_pkg::t_status status;
    gpio_pkg::t_status r_status;
    logic              r_valid;
    logic              req_xfer;

    // result register frees up when empty or when its transfer completes
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign req_xfer    = i_req.valid && i_req.ready;

    assign item.func       = i_req.func;
    assign item.reg_index  = i_req.reg_index;
    assign item.write_data = i_req.write_data;
    assign item.pin_levels = i_req.pin_levels;

    gpio_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (req_xfer),
        .i_item   (item),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (req_xfer) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_status <= status;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.read_data    = r_status.read_data;
    assign o_rsp.pin_drive    = r_status.pin_drive;
    assign o_rsp.drive_enable = r_status.drive_enable;
    assign o_rsp.open_drain   = r_status.open_drain;
    assign o_rsp.irq          = r_status.irq;

endmodule

`default_nettype wire

FILE: dv/gpio_port_with_edge_interrupts_test.sv
// Self-checking testbench for the GPIO port with edge interrupts: directed and
// random register, set/reset and pin-tick traffic checked against a shadow port.
// Depends on gpio_pkg, gpio_ifs and the gpio_port_with_edge_interrupts RTL.

module gpio_port_with_edge_interrupts_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package leaves unnamed: the spare function and a spare register slot.
    localparam logic [gpio_pkg::FUNC_W-1:0]  FN_UNUSED  = 2'd3;
    localparam logic [gpio_pkg::INDEX_W-1:0] REG_UNUSED = 4'd15;

    localparam int IDLE_LIMIT   = 1000;  // cycles with no transfer before giving up
    localparam int RANDOM_ITEMS = 1250;
    localparam int PRINT_LIMIT  = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gpio_req_if req_if ();
    gpio_rsp_if rsp_if ();

    gpio_port_with_edge_interrupts uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the port registers, updated once per accepted request.
    // ------------------------------------------------------------------
    logic [31:0] mode_sh, speed_sh, pull_sh, afl_sh, afh_sh;
    logic [15:0] otype_sh, odr_sh, idr_sh, rise_sh, fall_sh, mask_sh, pend_sh;

    gpio_pkg::t_status port_status_q[$];  // expected result transfers, oldest first
    int                error_count = 0;

    // Applies one request to the shadow registers and returns the status the
    // port must report for it. All outputs reflect state after the update.
    function automatic gpio_pkg::t_status apply_request(input gpio_pkg::t_item it);
        gpio_pkg::t_status st;
        logic [15:0]       rising, falling;
        st = '0;
        case (it.func)
            gpio_pkg::FN_READ: begin
                case (it.reg_index)
                    gpio_pkg::REG_MODE:    st.read_data = mode_sh;
                    gpio_pkg::REG_OTYPE:   st.read_data = {16'h0, otype_sh};
                    gpio_pkg::REG_SPEED:   st.read_data = speed_sh;
                    gpio_pkg::REG_PULL:    st.read_data = pull_sh;
                    gpio_pkg::REG_IDR:     st.read_data = {16'h0, idr_sh};
                    gpio_pkg::REG_ODR:     st.read_data = {16'h0, odr_sh};
                    gpio_pkg::REG_AFL:     st.read_data = afl_sh;
                    gpio_pkg::REG_AFH:     st.read_data = afh_sh;
                    gpio_pkg::REG_RISE:    st.read_data = {16'h0, rise_sh};
                    gpio_pkg::REG_FALL:    st.read_data = {16'h0, fall_sh};
                    gpio_pkg::REG_MASK:    st.read_data = {16'h0, mask_sh};
                    gpio_pkg::REG_PENDING: st.read_data = {16'h0, pend_sh};
                    default:               st.read_data = '0;  // set/reset and spares
                endcase
            end
            gpio_pkg::FN_WRITE: begin
                case (it.reg_index)
                    gpio_pkg::REG_MODE:     mode_sh  = it.write_data;
                    gpio_pkg::REG_OTYPE:    otype_sh = it.write_data[15:0];
                    gpio_pkg::REG_SPEED:    speed_sh = it.write_data;
                    gpio_pkg::REG_PULL:     pull_sh  = it.write_data;
                    gpio_pkg::REG_ODR:      odr_sh   = it.write_data[15:0];
                    // clear with the high half first, so set wins on overlap
                    gpio_pkg::REG_SETRESET: odr_sh   = (odr_sh & ~it.write_data[31:16])
                                                       | it.write_data[15:0];
                    gpio_pkg::REG_AFL:      afl_sh   = it.write_data;
                    gpio_pkg::REG_AFH:      afh_sh   = it.write_data;
                    gpio_pkg::REG_RISE:     rise_sh  = it.write_data[15:0];
                    gpio_pkg::REG_FALL:     fall_sh  = it.write_data[15:0];
                    gpio_pkg::REG_MASK:     mask_sh  = it.write_data[15:0];
                    gpio_pkg::REG_PENDING:  pend_sh  = pend_sh & ~it.write_data[15:0];
                    default: ;  // input data is read-only, spare slots ignore writes
                endcase
            end
            gpio_pkg::FN_TICK: begin
                // edges are taken against the last latched levels (zero after reset)
                rising  = it.pin_levels & ~idr_sh;
                falling = ~it.pin_levels & idr_sh;
                pend_sh = pend_sh | (((rising & rise_sh) | (falling & fall_sh)) & mask_sh);
                idr_sh  = it.pin_levels;
            end
            default: ;  // spare function: no state change
        endcase
        st.pin_drive  = odr_sh;
        st.open_drain = otype_sh;
        st.irq        = |pend_sh;
        for (int p = 0; p < 16; p++)
            st.drive_enable[p] = (mode_sh[2*p +: 2] == gpio_pkg::MODE_OUTPUT);
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Request side: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_item(input logic [gpio_pkg::FUNC_W-1:0]  func,
                             input logic [gpio_pkg::INDEX_W-1:0] idx,
                             input logic [gpio_pkg::DATA_W-1:0]  data,
                             input logic [gpio_pkg::PINS_W-1:0]  levels);
        gpio_pkg::t_item it;
        int unsigned     gap;
        it.func       = func;
        it.reg_index  = idx;
        it.write_data = data;
        it.pin_levels = levels;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // about a quarter of the bursts run straight on with no gap
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid      <= 1'b1;
        req_if.func       <= func;
        req_if.reg_index  <= idx;
        req_if.write_data <= data;
        req_if.pin_levels <= levels;
        do @(posedge i_clk); while (!req_if.ready);
        port_status_q.push_back(apply_request(it));
    endtask

    // ------------------------------------------------------------------
    // Result side: ready steps through a 16-bit pattern, reloaded after its last bit.
    // Some patterns are all ones (no stalls), others sparse or alternating.
    // Every pattern has at least one bit set, which bounds the longest stall.
    // ------------------------------------------------------------------
    logic [15:0] stall_word = 16'hFFFF;
    logic [3:0]  stall_step = 4'd0;

    always @(posedge i_clk) begin
        rsp_if.ready <= stall_word[stall_step];
        stall_step   <= stall_step + 4'd1;
        if (stall_step == 4'd15) begin
            case ($urandom_range(0, 3))
                0:       stall_word <= 16'hFFFF;
                1:       stall_word <= 16'h5555 << $urandom_range(0, 1);
                2:       stall_word <= 16'(($urandom() & $urandom()) | 32'h0001);
                default: stall_word <= 16'($urandom() | 32'h8000);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every result transfer against the oldest expectation.
    // ------------------------------------------------------------------
    gpio_pkg::t_status want_status;

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (port_status_q.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want_status = port_status_q.pop_front();
                if (rsp_if.read_data !== want_status.read_data)
                    report_mismatch($sformatf("read_data %h, expected %h",
                                              rsp_if.read_data, want_status.read_data));
                if (rsp_if.pin_drive !== want_status.pin_drive)
                    report_mismatch($sformatf("pin_drive %h, expected %h",
                                              rsp_if.pin_drive, want_status.pin_drive));
                if (rsp_if.drive_enable !== want_status.drive_enable)
                    report_mismatch($sformatf("drive_enable %h, expected %h",
                                              rsp_if.drive_enable, want_status.drive_enable));
                if (rsp_if.open_drain !== want_status.open_drain)
                    report_mismatch($sformatf("open_drain %h, expected %h",
                                              rsp_if.open_drain, want_status.open_drain));
                if (rsp_if.irq !== want_status.irq)
                    report_mismatch($sformatf("irq %b, expected %b",
                                              rsp_if.irq, want_status.irq));
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Spare function with every field bit high: no state change, zero read data.
    task automatic test_unknown_function();
        send_item(FN_UNUSED, REG_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // All-ones writes to a wide field register, the read-only input data,
    // the high alternate-function word and a spare slot, then read them back.
    // Finish with every pin in output mode so drive_enable goes all ones.
    task automatic test_register_extremes();
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_MODE, 32'hFFFF_FFFF, 16'h0);
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_IDR,  32'hFFFF_FFFF, 16'h0);
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_AFH,  32'hFFFF_FFFF, 16'h0);
        send_item(gpio_pkg::FN_WRITE, REG_UNUSED,         32'hFFFF_FFFF, 16'h0);
        send_item(gpio_pkg::FN_READ,  gpio_pkg::REG_MODE, 32'h0, 16'h0);
        send_item(gpio_pkg::FN_READ,  gpio_pkg::REG_IDR,  32'h0, 16'h0);
        send_item(gpio_pkg::FN_READ,  gpio_pkg::REG_AFH,  32'h0, 16'h0);
        send_item(gpio_pkg::FN_READ,  REG_UNUSED,         32'h0, 16'h0);
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_MODE, 32'h5555_5555, 16'h0);
    endtask

    // Set/reset: set wins where both halves are one, clear-only drops all
    // outputs, and the register itself reads zero.
    task automatic test_set_reset();
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_ODR,      32'h0, 16'h0);
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_SETRESET, 32'hFFFF_FFFF, 16'h0);
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_SETRESET, 32'hFFFF_0000, 16'h0);
        send_item(gpio_pkg::FN_READ,  gpio_pkg::REG_SETRESET, 32'h0, 16'h0);
    endtask

    // First tick after reset sees edges against zero; at reset all lines are
    // masked, so the low-byte rising edges are dropped. After unmasking, only
    // the high byte rises. Pending clears on write-one, four bits, then the rest.
    task automatic test_edge_interrupts();
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_RISE,    32'h0000_FFFF, 16'h0);
        send_item(gpio_pkg::FN_TICK,  gpio_pkg::REG_MODE,    32'h0, 16'h00FF);
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_MASK,    32'hFFFF_FFFF, 16'h0);
        send_item(gpio_pkg::FN_TICK,  gpio_pkg::REG_MODE,    32'h0, 16'hFFFF);
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_PENDING, 32'h0000_0F00, 16'h0);
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_PENDING, 32'hFFFF_FFFF, 16'h0);
        send_item(gpio_pkg::FN_WRITE, gpio_pkg::REG_FALL,    32'hFFFF_FFFF, 16'h0);
        send_item(gpio_pkg::FN_TICK,  gpio_pkg::REG_MODE,    32'h0, 16'h0000);
        send_item(gpio_pkg::FN_READ,  gpio_pkg::REG_PENDING, 32'h0, 16'h0);
    endtask

    // Random mix of reads, writes, ticks and the odd spare function over all
    // sixteen register slots. Pin levels either jump at random or toggle a
    // single pin, so isolated edges and quiet ticks both occur.
    task automatic test_random_traffic(input int count);
        logic [gpio_pkg::FUNC_W-1:0]  func;
        logic [gpio_pkg::INDEX_W-1:0] idx;
        logic [gpio_pkg::DATA_W-1:0]  data;
        logic [gpio_pkg::PINS_W-1:0]  levels;
        int unsigned                  sel;
        levels = '0;
        repeat (count) begin
            sel = $urandom_range(0, 19);
            if (sel < 6)
                func = gpio_pkg::FN_READ;
            else if (sel < 13)
                func = gpio_pkg::FN_WRITE;
            else if (sel < 19)
                func = gpio_pkg::FN_TICK;
            else
                func = FN_UNUSED;
            idx = gpio_pkg::INDEX_W'($urandom_range(0, 15));
            case ($urandom_range(0, 4))
                0:       data = '0;
                1:       data = '1;
                2:       data = 32'h1 << $urandom_range(0, 31);
                default: data = $urandom();
            endcase
            if ($urandom_range(0, 1) == 0)
                levels = gpio_pkg::PINS_W'($urandom_range(0, 16'hFFFF));
            else
                levels = levels ^ (16'h1 << $urandom_range(0, 15));
            send_item(func, idx, data, levels);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.func       <= gpio_pkg::FN_READ;
        req_if.reg_index  <= gpio_pkg::REG_MODE;
        req_if.write_data <= '0;
        req_if.pin_levels <= '0;
        mode_sh  = '0;
        speed_sh = '0;
        pull_sh  = '0;
        afl_sh   = '0;
        afh_sh   = '0;
        otype_sh = '0;
        odr_sh   = '0;
        idr_sh   = '0;
        rise_sh  = '0;
        fall_sh  = '0;
        mask_sh  = '0;
        pend_sh  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unknown_function();
        test_register_extremes();
        test_set_reset();
        test_edge_interrupts();
        test_random_traffic(RANDOM_ITEMS);

        req_if.valid <= 1'b0;
        // drain outstanding results, then idle for anything stray
        while (port_status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
design/gpio_pkg.sv
design/gpio_ifs.sv
design/gpio_regs.sv
design/gpio_port_with_edge_interrupts.sv
dv/gpio_port_with_edge_interrupts_test.sv
